// ===== rtl/core/cwte_pkg.sv =====
// Shared types and constants for the card whitelist with tag edge block.
// Holds the controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package cwte_pkg;

  // Width of a card identifier word
  localparam int unsigned ID_W = 32;

  // Action codes carried on the action field
  localparam logic ACT_ENROLL = 1'b0;
  localparam logic ACT_SCAN   = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } cwte_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;   // capture the accepted input word, restart the search
    logic rd_en;     // read the table at the search index
    logic inc_idx;   // advance the search index
    logic load_out;  // commit state updates and load the result word
  } cwte_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_search;  // scan with a present card and a non-empty table
    logic last_idx;     // search index points at the last valid entry
    logic out_free;     // result register can take a word this cycle
  } cwte_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/cwte_ctrl.sv =====
// Sequencing controller for the card whitelist with tag edge block.
// Drives datapath commands from a small state machine; uses cwte_pkg.
`default_nettype none

module cwte_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cwte_pkg::cwte_sts_t sts,
  output cwte_pkg::cwte_cmd_t    cmd
);
  import cwte_pkg::*;

  cwte_state_t state;
  cwte_state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through accept, search and commit
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = sts.need_search ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (sts.last_idx) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Drive handshake and datapath commands
  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.inc_idx = !sts.last_idx;
      end
      ST_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/cwte_dpath.sv =====
// Datapath for the card whitelist with tag edge block: identifier table,
// search index, last-card record and result register. Uses cwte_pkg.
`default_nettype none

module cwte_dpath #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cwte_pkg::cwte_cmd_t   cmd,
  output cwte_pkg::cwte_sts_t        sts,
  input  wire logic                  action,
  input  wire logic                  card_present,
  input  wire logic [cwte_pkg::ID_W-1:0] card_id,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       authorized,
  output logic                       new_tag,
  output logic [cwte_pkg::ID_W-1:0]  tag_id,
  output logic                       enroll_accepted
);
  import cwte_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Captured input word
  logic            act_r;
  logic            pres_r;
  logic [ID_W-1:0] id_r;

  // Table and search state
  logic [ID_W-1:0] table_mem [MAX_ENTRIES];
  logic [CW-1:0]   count;
  logic [IW-1:0]   idx;
  logic [ID_W-1:0] rd_data;
  logic            rd_pend;
  logic            hit;

  // Last card seen
  logic [ID_W-1:0] prev_id;
  logic            prev_present;

  logic room;
  logic fresh;

  assign room  = (count < CW'(MAX_ENTRIES));
  assign fresh = !prev_present || (prev_id != id_r);

  assign sts.need_search = (act_r == ACT_SCAN) && pres_r && (count != '0);
  assign sts.last_idx    = ((CW'(idx) + CW'(1)) == count);
  assign sts.out_free    = !out_valid || !out_stall;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r  <= action;
      pres_r <= card_present;
      id_r   <= card_id;
    end
  end

  // Step the search index
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      idx <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx + IW'(1);
    end
  end

  // Table write on enroll commit, registered read during search
  always_ff @(posedge clk) begin
    if (cmd.load_out && (act_r == ACT_ENROLL) && room) begin
      table_mem[count[IW-1:0]] <= id_r;
    end
    if (cmd.rd_en) begin
      rd_data <= table_mem[idx];
    end
  end

  // Compare returned entries against the scanned identifier
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      hit     <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
      if (cmd.load_in) begin
        hit <= 1'b0;
      end else if (rd_pend && (rd_data == id_r)) begin
        hit <= 1'b1;
      end
    end
  end

  // Commit the fill count and the last-card record
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      prev_id      <= '0;
      prev_present <= 1'b0;
    end else if (cmd.load_out) begin
      if (act_r == ACT_ENROLL) begin
        if (room) count <= count + CW'(1);
      end else if (!pres_r) begin
        prev_present <= 1'b0;
      end else begin
        prev_id      <= id_r;
        prev_present <= 1'b1;
      end
    end
  end

  // Load the result word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Scan fields only for a present card, enroll flag only for an enroll
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      authorized      <= (act_r == ACT_SCAN) && pres_r && hit;
      new_tag         <= (act_r == ACT_SCAN) && pres_r && fresh;
      tag_id          <= ((act_r == ACT_SCAN) && pres_r && fresh) ? id_r : '0;
      enroll_accepted <= (act_r == ACT_ENROLL) && room;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/card_whitelist_with_tag_edge.sv =====
// Card whitelist with tag edge detection: top level.
// An enroll, or a scan without a card or with an empty table, passes the idle,
// check and finish states; a scan with a card also searches in the scan state, one
// entry a cycle through the single read port of the identifier table, then drains.
// One word is handled at a time; the next word is taken while a result waits.
// Reset (rst, synchronous): empties the table, clears the last-card record.
`default_nettype none

module card_whitelist_with_tag_edge #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      action,
  input  wire logic                      card_present,
  input  wire logic [cwte_pkg::ID_W-1:0] card_id,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           authorized,
  output logic                           new_tag,
  output logic [cwte_pkg::ID_W-1:0]      tag_id,
  output logic                           enroll_accepted
);
  import cwte_pkg::*;

  cwte_cmd_t cmd;
  cwte_sts_t sts;

  // Sequence each word
  cwte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, search and report
  cwte_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .action          (action),
    .card_present    (card_present),
    .card_id         (card_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .authorized      (authorized),
    .new_tag         (new_tag),
    .tag_id          (tag_id),
    .enroll_accepted (enroll_accepted)
  );

endmodule

`default_nettype wire

// ===== sim/tb_card_whitelist_with_tag_edge.sv =====
// Testbench for card_whitelist_with_tag_edge: directed and random enroll/scan words.
// A scoreboard class predicts each result from the accepted words; depends on cwte_pkg.
`timescale 1ns / 100ps

module tb_card_whitelist_with_tag_edge;
  import cwte_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 16;
  localparam int unsigned RANDOM_WORDS = 1225;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;

  // Predict the whitelist and tag-edge results, hold them until they come out
  class card_scoreboard;
    logic [ID_W-1:0] roster[TABLE_DEPTH];
    int unsigned     roster_count;
    logic [ID_W-1:0] last_id;
    bit              seen_present;
    logic [ID_W+2:0] due_q[$];  // {authorized, new_tag, tag_id, enroll_accepted}
    int unsigned     errors;

    function new();
      roster_count = 0;
      last_id      = '0;
      seen_present = 1'b0;
      errors       = 0;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    // Apply one accepted word to the shadow state and queue its result
    function void note_word(logic act, logic present, logic [ID_W-1:0] id);
      logic            hit;
      logic            fresh;
      logic [ID_W-1:0] tag;
      logic            stored;
      hit    = 1'b0;
      fresh  = 1'b0;
      tag    = '0;
      stored = 1'b0;
      if (act == ACT_ENROLL) begin
        if (roster_count < TABLE_DEPTH) begin
          roster[roster_count] = id;
          roster_count++;
          stored = 1'b1;
        end
      end else if (!present) begin
        seen_present = 1'b0;
      end else begin
        for (int i = 0; i < roster_count; i++)
          if (roster[i] == id) hit = 1'b1;
        if (!seen_present || last_id != id) begin
          fresh = 1'b1;
          tag   = id;
        end
        last_id      = id;
        seen_present = 1'b1;
      end
      due_q.push_back({hit, fresh, tag, stored});
    endfunction

    // Compare one delivered result with the oldest prediction
    function void check_word(logic auth, logic fresh, logic [ID_W-1:0] tag, logic stored);
      logic            e_auth;
      logic            e_fresh;
      logic [ID_W-1:0] e_tag;
      logic            e_stored;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result auth=%0b new=%0b tag=%h acc=%0b",
                 $time, auth, fresh, tag, stored);
        errors++;
        return;
      end
      {e_auth, e_fresh, e_tag, e_stored} = due_q.pop_front();
      if (auth !== e_auth) begin
        $display("%0t: authorized expected %0b actual %0b", $time, e_auth, auth);
        errors++;
      end
      if (fresh !== e_fresh) begin
        $display("%0t: new_tag expected %0b actual %0b", $time, e_fresh, fresh);
        errors++;
      end
      if (tag !== e_tag) begin
        $display("%0t: tag_id expected %h actual %h", $time, e_tag, tag);
        errors++;
      end
      if (stored !== e_stored) begin
        $display("%0t: enroll_accepted expected %0b actual %0b", $time, e_stored, stored);
        errors++;
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            action = ACT_SCAN;
  logic            card_present = 1'b0;
  logic [ID_W-1:0] card_id = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            authorized;
  logic            new_tag;
  logic [ID_W-1:0] tag_id;
  logic            enroll_accepted;

  card_scoreboard sb;
  int unsigned    cycles = 0;
  int unsigned    stall_left = 0;

  card_whitelist_with_tag_edge #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .card_present(card_present),
    .card_id(card_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .authorized(authorized),
    .new_tag(new_tag),
    .tag_id(tag_id),
    .enroll_accepted(enroll_accepted)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stall the result side in runs of random level and length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      if ($urandom_range(99) < 35) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(1, 40);
      end else begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(1, 30);
      end
    end else begin
      stall_left = stall_left - 1;
    end
  end

  // Check every result word taken at this edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word(authorized, new_tag, tag_id, enroll_accepted);
  end

  // Present one word and hold it until taken; call right after a rising edge
  task automatic send_word(logic act, logic present, logic [ID_W-1:0] id);
    in_valid     <= 1'b1;
    action       <= act;
    card_present <= present;
    card_id      <= id;
    do @(posedge clk); while (in_stall);
    sb.note_word(act, present, id);
  endtask

  task automatic idle_cycles(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold the sender until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly scans of enrolled, repeated or near-miss cards, some absent reads and enrolls
  task automatic random_word(output logic act, output logic present,
                             output logic [ID_W-1:0] id);
    int unsigned roll;
    roll    = $urandom_range(99);
    act     = ACT_SCAN;
    present = 1'b1;
    id      = $urandom;
    if (roll < 8) begin
      act     = ACT_ENROLL;
      present = 1'($urandom_range(1));
    end else if (roll < 20) begin
      present = 1'b0;
    end else if (roll < 45) begin
      id = sb.last_id;
    end else if (roll < 80) begin
      id = sb.roster[$urandom_range(sb.roster_count - 1)];
    end else if (roll < 88) begin
      id = sb.roster[$urandom_range(sb.roster_count - 1)] ^ (32'h1 << $urandom_range(31));
    end
  endtask

  initial begin
    logic            act;
    logic            present;
    logic [ID_W-1:0] id;
    int unsigned     sent;
    int unsigned     burst;
    int unsigned     gap;
    bit              paused;
    sb     = new();
    paused = 1'b0;
    sent   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: absent card, first card on an empty table, both id extremes
    send_word(ACT_SCAN, 1'b0, 32'hFFFF_FFFF);
    send_word(ACT_SCAN, 1'b1, 32'h0000_0000);
    send_word(ACT_ENROLL, 1'b0, 32'h0000_0000);
    send_word(ACT_ENROLL, 1'b1, 32'hFFFF_FFFF);
    send_word(ACT_SCAN, 1'b1, 32'h0000_0000);
    send_word(ACT_SCAN, 1'b1, 32'hFFFF_FFFF);
    idle_cycles(3);
    send_word(ACT_SCAN, 1'b0, 32'hA5A5_A5A5);
    send_word(ACT_SCAN, 1'b1, 32'hFFFF_FFFF);
    // Fill the table, then enroll once more while full
    while (sb.roster_count < TABLE_DEPTH)
      send_word(ACT_ENROLL, 1'($urandom_range(1)), $urandom);
    send_word(ACT_ENROLL, 1'b0, 32'h1234_5678);
    send_word(ACT_SCAN, 1'b1, 32'h1234_5678);
    send_word(ACT_SCAN, 1'b1, sb.roster[TABLE_DEPTH-1]);
    drain_results();

    // Random bursts with random gaps
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && sent < RANDOM_WORDS; j++) begin
        random_word(act, present, id);
        send_word(act, present, id);
        sent++;
      end
      if (!paused && sent >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        drain_results();
      end else begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) idle_cycles(gap);
      end
    end

    // Wait out the last results, then let the block settle
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cwte_pkg.sv
rtl/core/cwte_ctrl.sv
rtl/core/cwte_dpath.sv
rtl/core/card_whitelist_with_tag_edge.sv
sim/tb_card_whitelist_with_tag_edge.sv
